// File: hdl/mced_pkg.sv
// package for the multi-car elevator dispatcher
// heading codes, item modes, the dwell reset value and sequencer states; no dependencies
package mced_pkg;
   typedef enum logic [1:0] {
      HD_STOP = 2'd0,
      HD_UP   = 2'd1,
      HD_DN   = 2'd2
   } heading_type;

   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_HALL  = 2'd1;
   localparam logic [1:0] MODE_CAR   = 2'd2;
   localparam logic [1:0] MODE_SPARE = 2'd3;

   localparam logic [3:0] DWELL_RESET = 4'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SCAN,
      ST_PEER,
      ST_PICK,
      ST_MOVE,
      ST_REPORT
   } state_type;
endpackage

// File: hdl/multi_car_elevator_dispatcher.sv
// multi-car elevator dispatcher, top level
// sequencer walks cars and floors with one shared compare unit; uses mced_pkg
//
// Usage: req_ beats carry one item (tick, hall call or car call); rsp_
// beats return one status per car in car order, rsp_last on the final car.
// The user must write dwell_ticks through csr_we only while the block
// is idle; the block itself does not enforce this. A call is applied in
// the first report cycle, before the first status beat. A tick walks
// every car: per car a decide step, a scan over the floor bitmaps, a
// pass over the peers through the shared distance comparator and a pick
// step, then a move step for all cars; a car that stops at its own floor
// takes only its decide step. Then CARS status beats follow, one per cycle while
// rsp_ready is high. The block takes a new item only after the last
// status beat has gone. When the receiver stalls the status beat holds.
// Reset puts every car at floor zero, stopped, with no calls pending,
// and dwell_ticks at 3.
module multi_car_elevator_dispatcher
   import mced_pkg::*;
#(
   parameter int FLOORS = 16,
   parameter int CARS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [3:0]  req_call_floor,
   input  logic        req_wants_down,
   input  logic [1:0]  req_car_select,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_car_id,
   output logic [3:0]  rsp_at_floor,
   output logic [1:0]  rsp_heading,
   output logic [3:0]  rsp_loading_left,
   output logic [3:0]  rsp_unloading_left,
   output logic [15:0] rsp_car_targets,
   output logic [15:0] rsp_up_calls,
   output logic [15:0] rsp_down_calls,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [3:0]  csr_wdata
);
   localparam int FW = (FLOORS > 2) ? $clog2(FLOORS) : 1;
   localparam int CW = (CARS > 1) ? $clog2(CARS) : 1;
   localparam int FCW = $clog2(FLOORS + 1);
   localparam int CCW = $clog2(CARS + 1);
   localparam logic [FW-1:0] TOP = FW'(FLOORS - 1);
   localparam logic [CW-1:0] LASTC = CW'(CARS - 1);

   state_type state_ff, state_in;

   logic [3:0]        dwell_ff;
   logic [FW-1:0]     pos_ff   [CARS];
   heading_type       hd_ff    [CARS];
   logic [FLOORS-1:0] dest_ff  [CARS];
   logic [3:0]        load_ff  [CARS];
   logic [3:0]        unld_ff  [CARS];
   logic [FLOORS-1:0] up_ff, dn_ff;

   logic [CW-1:0]  car_ff;
   logic [FCW-1:0] fl_ff;
   logic [CCW-1:0] peer_ff;
   logic [CCW-1:0] rsp_idx_ff;
   heading_type    hdw_ff;   // working heading of the car being decided
   logic           da_ff, db_ff, ra_ff, rb_ff;
   logic [FW-1:0]  nhi_ff, nlo_ff;
   logic           bu_ff, bd_ff, ou_ff, od_ff;

   logic [1:0]  mode_ff;
   logic [3:0]  cfl_ff;
   logic        cdn_ff;
   logic [1:0]  csel_ff;

   // first report cycle applies the call; beats start the cycle after
   logic rsp_valid_seen_ff;

   // per-car view for current car
   logic [FW-1:0]     cpos;
   logic [FLOORS-1:0] cdest;
   heading_type       chd;
   logic              at_top, at_bot;
   assign cpos  = pos_ff[car_ff];
   assign cdest = dest_ff[car_ff];
   assign chd   = hd_ff[car_ff];
   assign at_top = (cpos == TOP);
   assign at_bot = (cpos == '0);

   // shared scan unit: one floor per cycle
   logic [FW-1:0] sfl;
   logic          s_dest, s_req, s_above, s_below;
   assign sfl    = fl_ff[FW-1:0];
   assign s_dest = cdest[sfl];
   assign s_req  = up_ff[sfl] | dn_ff[sfl];
   assign s_above = sfl > cpos;
   assign s_below = sfl < cpos;

   // shared peer compare unit: one car per cycle
   logic [CW-1:0]  pj;
   logic [FW-1:0]  of;
   heading_type    ohd;
   logic           p_up, p_dn;
   logic [FW:0]    d_lo_of, d_pos_lo, d_of_hi, d_hi_pos;
   assign pj  = peer_ff[CW-1:0];
   assign of  = pos_ff[pj];
   assign ohd = hd_ff[pj];
   assign p_up = (ohd == HD_UP) || (ohd == HD_STOP);
   assign p_dn = (ohd == HD_DN) || (ohd == HD_STOP);
   assign d_lo_of  = {1'b0, nlo_ff} - {1'b0, of};
   assign d_pos_lo = {1'b0, cpos} - {1'b0, nlo_ff};
   assign d_of_hi  = {1'b0, of} - {1'b0, nhi_ff};
   assign d_hi_pos = {1'b0, nhi_ff} - {1'b0, cpos};

   // working heading after the shaft-edge fixup, with timers counted down
   heading_type hd_fix;
   logic [3:0]  ld_dec, ul_dec;
   always_comb begin
      hd_fix = chd;
      if ((at_top && chd == HD_UP) || (at_bot && chd == HD_DN)) begin
         hd_fix = HD_STOP;
      end
      ld_dec = (load_ff[car_ff] != 4'd0) ? load_ff[car_ff] - 4'd1 : 4'd0;
      ul_dec = (unld_ff[car_ff] != 4'd0) ? unld_ff[car_ff] - 4'd1 : 4'd0;
   end

   logic scan_done, peer_done, last_car, rsp_done;
   assign scan_done = (fl_ff == FCW'(FLOORS - 1));
   assign peer_done = (peer_ff == CCW'(CARS - 1));
   assign last_car  = (car_ff == LASTC);
   assign rsp_done  = (rsp_idx_ff == CCW'(CARS - 1)) && rsp_valid && rsp_ready;

   logic dec_hit;   // decide cycle resolves the car at its own floor
   assign dec_hit = cdest[cpos]
      || (up_ff[cpos] && (hd_fix != HD_DN))
      || (dn_ff[cpos] && (hd_fix != HD_UP));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_mode == MODE_TICK) ? ST_DECIDE : ST_REPORT;
            end
         end
         ST_DECIDE: begin
            if (dec_hit) begin
               state_in = last_car ? ST_MOVE : ST_DECIDE;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_PEER;
            end
         end
         ST_PEER: begin
            if (peer_done) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: state_in = last_car ? ST_MOVE : ST_DECIDE;
         ST_MOVE: state_in = ST_REPORT;
         ST_REPORT: begin
            if (rsp_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      rsp_valid = (state_ff == ST_REPORT) && rsp_valid_seen_ff;
   end

   logic [CW-1:0] ridx;
   assign ridx = rsp_idx_ff[CW-1:0];
   assign rsp_car_id         = 2'(ridx);
   assign rsp_at_floor       = 4'(pos_ff[ridx]);
   assign rsp_heading        = hd_ff[ridx];
   assign rsp_loading_left   = load_ff[ridx];
   assign rsp_unloading_left = unld_ff[ridx];
   assign rsp_car_targets    = 16'(dest_ff[ridx]);
   assign rsp_up_calls       = 16'(up_ff);
   assign rsp_down_calls     = 16'(dn_ff);
   assign rsp_last           = (rsp_idx_ff == CCW'(CARS - 1));

   logic [FW-1:0] fsel;
   logic [CW-1:0] csel;
   assign fsel = cfl_ff[FW-1:0];
   assign csel = csel_ff[CW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         dwell_ff   <= DWELL_RESET;
         up_ff      <= '0;
         dn_ff      <= '0;
         car_ff     <= '0;
         fl_ff      <= '0;
         peer_ff    <= '0;
         rsp_idx_ff <= '0;
         hdw_ff     <= HD_STOP;
         for (int c = 0; c < CARS; c++) begin
            pos_ff[c]  <= '0;
            hd_ff[c]   <= HD_STOP;
            dest_ff[c] <= '0;
            load_ff[c] <= '0;
            unld_ff[c] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            dwell_ff <= csr_wdata;
         end
         case (state_ff)
            ST_IDLE: begin
               car_ff     <= '0;
               rsp_idx_ff <= '0;
               if (req_valid) begin
                  mode_ff <= req_mode;
                  cfl_ff  <= req_call_floor;
                  cdn_ff  <= req_wants_down;
                  csel_ff <= req_car_select;
               end
            end
            ST_DECIDE: begin
               hdw_ff <= hd_fix;
               da_ff <= 1'b0; db_ff <= 1'b0; ra_ff <= 1'b0; rb_ff <= 1'b0;
               nhi_ff <= '0; nlo_ff <= '0;
               bu_ff <= 1'b0; bd_ff <= 1'b0; ou_ff <= 1'b0; od_ff <= 1'b0;
               fl_ff <= '0;
               peer_ff <= '0;
               if (cdest[cpos]) begin
                  dest_ff[car_ff][cpos] <= 1'b0;
                  load_ff[car_ff] <= ld_dec;
                  unld_ff[car_ff] <= (ul_dec == 4'd0) ? dwell_ff : ul_dec;
                  hd_ff[car_ff] <= hd_fix;
                  car_ff <= car_ff + CW'(1);
               end else if (up_ff[cpos] && hd_fix != HD_DN) begin
                  up_ff[cpos] <= 1'b0;
                  load_ff[car_ff] <= (ld_dec == 4'd0) ? dwell_ff : ld_dec;
                  unld_ff[car_ff] <= ul_dec;
                  hd_ff[car_ff] <= HD_UP;
                  car_ff <= car_ff + CW'(1);
               end else if (dn_ff[cpos] && hd_fix != HD_UP) begin
                  dn_ff[cpos] <= 1'b0;
                  load_ff[car_ff] <= (ld_dec == 4'd0) ? dwell_ff : ld_dec;
                  unld_ff[car_ff] <= ul_dec;
                  hd_ff[car_ff] <= HD_DN;
                  car_ff <= car_ff + CW'(1);
               end else begin
                  load_ff[car_ff] <= ld_dec;
                  unld_ff[car_ff] <= ul_dec;
               end
            end
            ST_SCAN: begin
               if (s_above) begin
                  if (s_dest) da_ff <= 1'b1;
                  if (s_req && !ra_ff) begin
                     ra_ff  <= 1'b1;
                     nhi_ff <= sfl;
                  end
               end
               if (s_below) begin
                  if (s_dest) db_ff <= 1'b1;
                  if (s_req) begin
                     // ascending scan: the last one below is the nearest
                     rb_ff  <= 1'b1;
                     nlo_ff <= sfl;
                  end
               end
               fl_ff <= fl_ff + FCW'(1);
            end
            ST_PEER: begin
               if (pj != car_ff) begin
                  if (p_up && ra_ff &&
                      ((of > cpos && of <= nhi_ff) || (of == cpos && pj < car_ff)))
                     bu_ff <= 1'b1;
                  if (p_dn && rb_ff &&
                      ((of < cpos && of >= nlo_ff) || (of == cpos && pj < car_ff)))
                     bd_ff <= 1'b1;
                  if (p_up && rb_ff && nlo_ff >= of && d_lo_of < d_pos_lo)
                     ou_ff <= 1'b1;
                  if (p_dn && ra_ff && of >= nhi_ff && d_of_hi < d_hi_pos)
                     od_ff <= 1'b1;
               end
               peer_ff <= peer_ff + CCW'(1);
            end
            ST_PICK: begin
               if (!da_ff && !ra_ff && !db_ff && !rb_ff)
                  hd_ff[car_ff] <= HD_STOP;
               else if (da_ff && (hdw_ff == HD_STOP || hdw_ff == HD_UP))
                  hd_ff[car_ff] <= HD_UP;
               else if (db_ff && (hdw_ff == HD_STOP || hdw_ff == HD_DN))
                  hd_ff[car_ff] <= HD_DN;
               else if ((hdw_ff == HD_UP || hdw_ff == HD_STOP) && ra_ff &&
                        !bu_ff && !od_ff)
                  hd_ff[car_ff] <= HD_UP;
               else if ((hdw_ff == HD_DN || hdw_ff == HD_STOP) && rb_ff &&
                        !bd_ff && !ou_ff)
                  hd_ff[car_ff] <= HD_DN;
               else
                  hd_ff[car_ff] <= HD_STOP;
               car_ff <= car_ff + CW'(1);
            end
            ST_MOVE: begin
               for (int c = 0; c < CARS; c++) begin
                  if (load_ff[c] == 4'd0 && unld_ff[c] == 4'd0) begin
                     if (hd_ff[c] == HD_UP && pos_ff[c] != TOP)
                        pos_ff[c] <= pos_ff[c] + FW'(1);
                     else if (hd_ff[c] == HD_DN && pos_ff[c] != '0)
                        pos_ff[c] <= pos_ff[c] - FW'(1);
                  end
               end
            end
            ST_REPORT: begin
               if (rsp_idx_ff == '0 && !rsp_valid_seen_ff) begin
                  if (mode_ff == MODE_HALL && {1'b0, cfl_ff} < 5'(FLOORS)) begin
                     if (cdn_ff) dn_ff[fsel] <= 1'b1;
                     else        up_ff[fsel] <= 1'b1;
                  end else if (mode_ff == MODE_CAR && {1'b0, cfl_ff} < 5'(FLOORS) &&
                               {1'b0, csel_ff} < 3'(CARS) && fsel != pos_ff[csel]) begin
                     if (hd_ff[csel] == HD_STOP)
                        hd_ff[csel] <= (fsel < pos_ff[csel]) ? HD_DN : HD_UP;
                     dest_ff[csel][fsel] <= 1'b1;
                  end
               end
               if (rsp_valid_seen_ff && rsp_ready) begin
                  rsp_idx_ff <= rsp_idx_ff + CCW'(1);
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_seen_ff <= 1'b0;
      end else begin
         rsp_valid_seen_ff <= (state_ff == ST_REPORT) && !rsp_done;
      end
   end

   property p_idle_ready;
      @(posedge clock) disable iff (reset) (state_ff == ST_IDLE) |-> !rsp_valid;
   endproperty
   a_idle_ready: assert property (p_idle_ready) else $error("beat while idle");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item accepted while busy");

   a_rsp_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_idx_ff < CCW'(CARS)))
      else $error("status index out of range");
endmodule
